/* design/cda_pkg.sv */
package cda_pkg;

    localparam logic [13:0] YEAR_MAX   = 14'd9999;
    localparam logic [13:0] YEAR_RESET = 14'd2001;
    localparam logic [4:0]  DAY_RESET  = 5'd1;
    localparam logic [3:0]  MONTH_RESET = 4'd1;
    localparam logic [3:0]  MONTH_FEB  = 4'd2;
    localparam logic [3:0]  MONTH_DEC  = 4'd12;
    localparam logic [2:0]  WDAY_SAT   = 3'd5;
    localparam logic [2:0]  WDAY_SUN   = 3'd6;

    typedef enum logic [1:0] {
        ACT_SET     = 2'd0,
        ACT_ADD     = 2'd1,
        ACT_WORKDAY = 2'd2,
        ACT_NONE    = 2'd3
    } cda_action_t;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_INVALID  = 2'd1,
        STS_OVERFLOW = 2'd2
    } cda_status_t;

    typedef enum logic [1:0] {
        GOAL_CHECK = 2'd0,
        GOAL_ADV   = 2'd1,
        GOAL_FINAL = 2'd2
    } cda_goal_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_YS_A,
        ST_YS_B,
        ST_YS_C,
        ST_CHECK,
        ST_ADV,
        ST_WS_A,
        ST_WS_B,
        ST_WSUM,
        ST_WMOD,
        ST_WDEC,
        ST_OUT
    } cda_state_t;

    // sequencer to datapath
    typedef struct packed {
        logic        in_ready;
        logic        accept;
        logic        out_valid;
        logic        leap_load;
        logic        restore;
        cda_status_t status_val;
        logic        adv_step;
        logic        wd_add_en;
        logic [1:0]  wd_add;
        logic        split_prev;
        logic        wsum_load;
        logic        wday_load;
        logic        commit;
    } cda_ctl_t;

    // datapath to sequencer
    typedef struct packed {
        logic       set_ok;
        logic       adv_more;
        logic       month_wrap;
        logic       year_max;
        logic [2:0] weekday;
    } cda_flags_t;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // days before the first of month m in a common year
    function automatic logic [8:0] cum_days(input logic [3:0] m);
        logic [8:0] c;
        case (m)
            4'd2:    c = 9'd31;
            4'd3:    c = 9'd59;
            4'd4:    c = 9'd90;
            4'd5:    c = 9'd120;
            4'd6:    c = 9'd151;
            4'd7:    c = 9'd181;
            4'd8:    c = 9'd212;
            4'd9:    c = 9'd243;
            4'd10:   c = 9'd273;
            4'd11:   c = 9'd304;
            4'd12:   c = 9'd334;
            default: c = 9'd0;
        endcase
        return c;
    endfunction

    // floor(2.6*mm - 0.2) with mm counted from march
    function automatic logic [4:0] month_term(input logic [3:0] m);
        logic [4:0] t;
        case (m)
            4'd1:    t = 5'd28;
            4'd2:    t = 5'd31;
            4'd3:    t = 5'd2;
            4'd4:    t = 5'd5;
            4'd5:    t = 5'd7;
            4'd6:    t = 5'd10;
            4'd7:    t = 5'd12;
            4'd8:    t = 5'd15;
            4'd9:    t = 5'd18;
            4'd10:   t = 5'd20;
            4'd11:   t = 5'd23;
            4'd12:   t = 5'd25;
            default: t = 5'd0;
        endcase
        return t;
    endfunction

    // 8 = 1 mod 7, so octal digits fold
    function automatic logic [2:0] mod7(input logic [10:0] v);
        logic [4:0] s1;
        logic [3:0] s2;
        logic [3:0] s3;
        s1 = 5'(v[2:0]) + 5'(v[5:3]) + 5'(v[8:6]) + 5'(v[10:9]);
        s2 = 4'(s1[2:0]) + 4'(s1[4:3]);
        s3 = (s2 >= 4'd7) ? (s2 - 4'd7) : s2;
        return s3[2:0];
    endfunction

endpackage

/* design/cda_if.sv */
interface cda_in_if #(
    parameter int COUNT_BITS = 10
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            action;
    logic [4:0]            set_day;
    logic [3:0]            set_month;
    logic [13:0]           set_year;
    logic [COUNT_BITS-1:0] day_count;

    modport source (
        output valid, action, set_day, set_month, set_year, day_count,
        input  ready
    );
    modport sink (
        input  valid, action, set_day, set_month, set_year, day_count,
        output ready
    );
endinterface

interface cda_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  day_out;
    logic [3:0]  month_out;
    logic [13:0] year_out;
    logic [2:0]  weekday_out;
    logic [8:0]  year_day;
    logic        leap_flag;
    logic [1:0]  status;

    modport source (
        output valid, day_out, month_out, year_out, weekday_out, year_day,
               leap_flag, status,
        input  ready
    );
    modport sink (
        input  valid, day_out, month_out, year_out, weekday_out, year_day,
               leap_flag, status,
        output ready
    );
endinterface

/* design/cda_year_split.sv */
module cda_year_split (
    input  logic        clk,
    input  logic [13:0] year,
    output logic [7:0]  cent,
    output logic [6:0]  rem,
    output logic        leap
);
    // year / 100 as (year * 5243) >> 19, exact over 14 bits
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    logic [26:0] prod;
    logic [13:0] y1_reg, y1_next;
    logic [7:0]  q1_reg, q1_next;
    logic [13:0] diff;
    logic [7:0]  cent_reg, cent_next;
    logic [6:0]  rem_reg, rem_next;
    logic        leap_reg, leap_next;

    always_comb
    begin
        prod    = 27'(year) * 27'(RECIP_100);
        y1_next = year;
        q1_next = prod[RECIP_SHIFT+7:RECIP_SHIFT];
    end

    always_comb
    begin
        diff      = y1_reg - (14'(q1_reg) * 14'd100);
        cent_next = q1_reg;
        rem_next  = diff[6:0];
        if (diff == 14'd0)
        begin
            leap_next = (q1_reg[1:0] == 2'd0);
        end
        else
        begin
            leap_next = (y1_reg[1:0] == 2'd0);
        end
    end

    always_ff @(posedge clk)
    begin
        y1_reg   <= y1_next;
        q1_reg   <= q1_next;
        cent_reg <= cent_next;
        rem_reg  <= rem_next;
        leap_reg <= leap_next;
    end

    assign cent = cent_reg;
    assign rem  = rem_reg;
    assign leap = leap_reg;

endmodule

/* design/cda_ctrl.sv */
module cda_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          action,
    input  logic                out_ready,
    input  cda_pkg::cda_flags_t flags,
    output cda_pkg::cda_ctl_t   ctl
);
    import cda_pkg::*;

    cda_state_t  state_reg, state_next;
    cda_goal_t   goal_reg, goal_next;
    cda_action_t act_reg, act_next;
    logic [1:0]  phase_reg, phase_next;
    logic        skip_ok;
    logic        adv_fail;

    assign skip_ok  = (act_reg == ACT_WORKDAY) && (phase_reg != 2'd2);
    assign adv_fail = flags.adv_more && flags.month_wrap && flags.year_max;

    // next state
    always_comb
    begin
        state_next = state_reg;
        goal_next  = goal_reg;
        act_next   = act_reg;
        phase_next = phase_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    act_next   = cda_action_t'(action);
                    phase_next = 2'd0;
                    state_next = ST_YS_A;
                    case (cda_action_t'(action))
                        ACT_SET:     goal_next = GOAL_CHECK;
                        ACT_ADD:     goal_next = GOAL_ADV;
                        ACT_WORKDAY: goal_next = GOAL_ADV;
                        default:     goal_next = GOAL_FINAL;
                    endcase
                end
            end
            ST_YS_A: state_next = ST_YS_B;
            ST_YS_B: state_next = ST_YS_C;
            ST_YS_C:
            begin
                case (goal_reg)
                    GOAL_CHECK: state_next = ST_CHECK;
                    GOAL_ADV:   state_next = ST_ADV;
                    default:    state_next = ST_WS_A;
                endcase
            end
            ST_CHECK:
            begin
                if (flags.set_ok)
                begin
                    state_next = ST_WS_A;
                end
                else
                begin
                    goal_next  = GOAL_FINAL;
                    state_next = ST_YS_A;
                end
            end
            ST_ADV:
            begin
                if (!flags.adv_more)
                begin
                    state_next = ST_WS_A;
                end
                else if (adv_fail)
                begin
                    goal_next  = GOAL_FINAL;
                    phase_next = 2'd2;
                    state_next = ST_YS_A;
                end
                else if (flags.month_wrap)
                begin
                    goal_next  = GOAL_ADV;
                    state_next = ST_YS_A;
                end
            end
            ST_WS_A: state_next = ST_WS_B;
            ST_WS_B: state_next = ST_WSUM;
            ST_WSUM: state_next = ST_WMOD;
            ST_WMOD: state_next = ST_WDEC;
            ST_WDEC:
            begin
                if (skip_ok && phase_reg == 2'd0 && flags.weekday == WDAY_SAT)
                begin
                    phase_next = 2'd1;
                    state_next = ST_ADV;
                end
                else if (skip_ok && flags.weekday == WDAY_SUN)
                begin
                    phase_next = 2'd2;
                    state_next = ST_ADV;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        ctl = '0;
        ctl.status_val = STS_OK;
        case (state_reg)
            ST_IDLE:
            begin
                ctl.in_ready = 1'b1;
                ctl.accept   = in_valid;
            end
            ST_YS_C: ctl.leap_load = 1'b1;
            ST_CHECK:
            begin
                if (!flags.set_ok)
                begin
                    ctl.restore    = 1'b1;
                    ctl.status_val = STS_INVALID;
                end
            end
            ST_ADV:
            begin
                if (adv_fail)
                begin
                    ctl.restore    = 1'b1;
                    ctl.status_val = STS_OVERFLOW;
                end
                else
                begin
                    ctl.adv_step = flags.adv_more;
                end
            end
            ST_WS_A: ctl.split_prev = 1'b1;
            ST_WS_B: ctl.split_prev = 1'b1;
            ST_WSUM: ctl.wsum_load  = 1'b1;
            ST_WMOD: ctl.wday_load  = 1'b1;
            ST_WDEC:
            begin
                if (skip_ok && phase_reg == 2'd0 && flags.weekday == WDAY_SAT)
                begin
                    ctl.wd_add_en = 1'b1;
                    ctl.wd_add    = 2'd2;
                end
                else if (skip_ok && flags.weekday == WDAY_SUN)
                begin
                    ctl.wd_add_en = 1'b1;
                    ctl.wd_add    = 2'd1;
                end
                else
                begin
                    ctl.commit = 1'b1;
                end
            end
            ST_OUT: ctl.out_valid = 1'b1;
            default: ctl.out_valid = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            goal_reg  <= GOAL_FINAL;
            act_reg   <= ACT_NONE;
            phase_reg <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            goal_reg  <= goal_next;
            act_reg   <= act_next;
            phase_reg <= phase_next;
        end
    end

endmodule

/* design/calendar_date_advance.sv */
// channel | role | payload
// --------+------+----------------------------------------------------------
// cmd     | sink | action, set_day, set_month, set_year, day_count
// res     | src  | day_out, month_out, year_out, weekday_out, year_day,
//         |      | leap_flag, status
//
// one transaction at a time; cmd.ready is high only while idle
// set checks the date; add and next workday walk it a month at a time and rerun
// the year splitter (shared with the weekday sum) at each year boundary; a refused
// set or add restores the committed date; a weekend skip walks on to the monday
// reset gives 2001-01-01; no memory, no clearing pass
// a result is held on res until taken; a stalled res holds the block
module calendar_date_advance #(
    parameter int COUNT_BITS = 10
) (
    input logic      clk,
    input logic      rst_n,
    cda_in_if.sink   cmd,
    cda_out_if.source res
);
    import cda_pkg::*;

    // working day must hold the current day plus the largest count
    localparam int DW = ((COUNT_BITS > 5) ? COUNT_BITS : 5) + 1;

    cda_ctl_t   ctl;
    cda_flags_t flags;

    // committed date
    logic [4:0]  cur_day_reg, cur_day_next;
    logic [3:0]  cur_month_reg, cur_month_next;
    logic [13:0] cur_year_reg, cur_year_next;

    // working date under the walk
    logic [DW-1:0] wd_reg, wd_next;
    logic [3:0]    wm_reg, wm_next;
    logic [13:0]   wy_reg, wy_next;
    logic          leap_reg, leap_next;
    cda_status_t   status_reg, status_next;
    logic [10:0]   wsum_reg, wsum_next;
    logic [2:0]    wday_reg, wday_next;

    logic [4:0]  len;
    logic [13:0] split_year;
    logic [7:0]  cent;
    logic [6:0]  rem;
    logic        split_leap;
    logic [2:0]  w7;
    logic [8:0]  doy;

    cda_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .action    (cmd.action),
        .out_ready (res.ready),
        .flags     (flags),
        .ctl       (ctl)
    );

    // jan and feb take the weekday from the previous year
    assign split_year = (ctl.split_prev && wm_reg <= MONTH_FEB) ? (wy_reg - 14'd1) : wy_reg;

    cda_year_split u_split (
        .clk  (clk),
        .year (split_year),
        .cent (cent),
        .rem  (rem),
        .leap (split_leap)
    );

    // month length of the working month, leap_reg tracks wy_reg
    assign len = month_len(wm_reg, leap_reg);

    always_comb
    begin
        flags.adv_more   = (wd_reg > DW'(len));
        flags.month_wrap = (wm_reg >= MONTH_DEC);
        flags.year_max   = (wy_reg >= YEAR_MAX);
        flags.weekday    = wday_reg;
        flags.set_ok     = (wm_reg >= 4'd1) && (wm_reg <= MONTH_DEC)
                        && (wy_reg >= 14'd1) && (wy_reg <= YEAR_MAX)
                        && (wd_reg != '0) && (wd_reg <= DW'(len));
    end

    // working date update
    always_comb
    begin
        wd_next     = wd_reg;
        wm_next     = wm_reg;
        wy_next     = wy_reg;
        status_next = status_reg;
        if (ctl.accept)
        begin
            status_next = STS_OK;
            wm_next     = cur_month_reg;
            wy_next     = cur_year_reg;
            case (cda_action_t'(cmd.action))
                ACT_SET:
                begin
                    wd_next = DW'(cmd.set_day);
                    wm_next = cmd.set_month;
                    wy_next = cmd.set_year;
                end
                ACT_ADD:     wd_next = DW'(cur_day_reg) + DW'(cmd.day_count);
                ACT_WORKDAY: wd_next = DW'(cur_day_reg) + DW'(1);
                default:     wd_next = DW'(cur_day_reg);
            endcase
        end
        else if (ctl.restore)
        begin
            wd_next     = DW'(cur_day_reg);
            wm_next     = cur_month_reg;
            wy_next     = cur_year_reg;
            status_next = ctl.status_val;
        end
        else if (ctl.adv_step)
        begin
            // one month per cycle, pausing for the year split after a year wrap
            wd_next = wd_reg - DW'(len);
            if (flags.month_wrap)
            begin
                wm_next = 4'd1;
                wy_next = wy_reg + 14'd1;
            end
            else
            begin
                wm_next = wm_reg + 4'd1;
            end
        end
        else if (ctl.wd_add_en)
        begin
            // weekend skip
            wd_next = wd_reg + DW'(ctl.wd_add);
        end
    end

    assign leap_next = ctl.leap_load ? split_leap : leap_reg;

    // congruence: d + month term + r + r/4 + c/4 + 5c
    always_comb
    begin
        wsum_next = wsum_reg;
        if (ctl.wsum_load)
        begin
            wsum_next = 11'(wd_reg[4:0]) + 11'(month_term(wm_reg)) + 11'(rem)
                      + 11'(rem[6:2]) + 11'(cent[7:2])
                      + {1'b0, cent, 2'b00} + 11'(cent);
        end
    end

    // sunday-based to monday-based
    assign w7 = mod7(wsum_reg);

    always_comb
    begin
        wday_next = wday_reg;
        if (ctl.wday_load)
        begin
            wday_next = (w7 == 3'd0) ? 3'd6 : (w7 - 3'd1);
        end
    end

    always_comb
    begin
        cur_day_next   = cur_day_reg;
        cur_month_next = cur_month_reg;
        cur_year_next  = cur_year_reg;
        if (ctl.commit)
        begin
            cur_day_next   = wd_reg[4:0];
            cur_month_next = wm_reg;
            cur_year_next  = wy_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_day_reg   <= DAY_RESET;
            cur_month_reg <= MONTH_RESET;
            cur_year_reg  <= YEAR_RESET;
        end
        else
        begin
            cur_day_reg   <= cur_day_next;
            cur_month_reg <= cur_month_next;
            cur_year_reg  <= cur_year_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wd_reg     <= wd_next;
        wm_reg     <= wm_next;
        wy_reg     <= wy_next;
        leap_reg   <= leap_next;
        status_reg <= status_next;
        wsum_reg   <= wsum_next;
        wday_reg   <= wday_next;
    end

    // day of year from the cumulative month table
    assign doy = cum_days(cur_month_reg) + 9'(cur_day_reg)
               + 9'(leap_reg && (cur_month_reg > MONTH_FEB));

    assign cmd.ready       = ctl.in_ready;
    assign res.valid       = ctl.out_valid;
    assign res.day_out     = cur_day_reg;
    assign res.month_out   = cur_month_reg;
    assign res.year_out    = cur_year_reg;
    assign res.weekday_out = wday_reg;
    assign res.year_day    = doy;
    assign res.leap_flag   = leap_reg;
    assign res.status      = status_reg;

endmodule
